[sv/nibble_handshake_pad_reader_defines.svh]
// assertion macros shared by the pad reader rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef NIBBLE_HANDSHAKE_PAD_READER_DEFINES_SVH
`define NIBBLE_HANDSHAKE_PAD_READER_DEFINES_SVH

`ifndef ASSERT_OFF

`define NHPR_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pad reader check failed: invariant");

`define NHPR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pad reader check failed: implication");

`define NHPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pad reader check failed: next cycle");

`else

`define NHPR_ASSERT_ALWAYS(label, clk, rst, cond)
`define NHPR_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define NHPR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/nhpr_pkg.sv]
// types and constants for the nibble handshake pad reader
// no dependencies; used by nibble_handshake_pad_reader
package nhpr_pkg;

   localparam int NumBytesDefault = 8;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   localparam logic [7:0] SettleReset  = 8'd2;
   localparam logic [7:0] TimeoutReset = 8'd100;
   localparam logic [7:0] EndReset     = 8'd4;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SETTLE  = 2'd0,
      CSR_TIMEOUT = 2'd1,
      CSR_END     = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_SET_H0  = 4'd1,
      PH_SET_L0  = 4'd2,
      PH_WAIT_LO = 4'd3,
      PH_SET_HN  = 4'd4,
      PH_WAIT_HI = 4'd5,
      PH_SET_LN  = 4'd6,
      PH_END1    = 4'd7,
      PH_END2    = 4'd8
   } phase_type;

   typedef struct packed {
      logic       th_level;
      logic       tr_level;
      logic       byte_valid;
      logic [2:0] byte_index;
      logic [7:0] byte_value;
      logic       timed_out;
      logic       done_res;
      logic       busy_res;
   } rsp_type;

endpackage

[sv/nibble_handshake_pad_reader.sv]
// nibble handshake pad reader: tick sequencer with a two-entry result buffer
// depends on nhpr_pkg and nibble_handshake_pad_reader_defines.svh
//
// usage
//  - every req item is one microsecond tick of sampled pad pins (data nibble,
//    tl level) plus a start request; each accepted item yields exactly one rsp
//    item carrying the th/tr levels to drive and any byte completed on that tick
//  - the rsp item for a req item is registered, in the output register or, while the output is held, in the skid entry
//  - throughput: one item per cycle while req_stall is low; the sequencer takes one step per item
//  - the result side is an output register plus one skid entry, so a new item
//    is still taken on the cycle a result first stalls; req_stall rises only
//    once both entries hold results, and it comes straight from a flop
//  - a read: th/tr high, settle, sample high nibble, th low, settle, sample low
//    nibble (byte 0); later bytes toggle tr and wait for tl to follow before
//    each settle; a tl wait past timeout_ticks gives a zero byte, sets timed_out
//    and ends the read; every read closes with end wait, th/tr high, end wait
//  - csr writes (settle, timeout, end ticks) take effect at once; write them
//    only while the block is idle; index three is ignored
//  - reset (synchronous, active high) empties both result entries, puts the
//    sequencer in idle with th/tr high and restores the csr defaults
module nibble_handshake_pad_reader #(
   parameter int NUM_BYTES = nhpr_pkg::NumBytesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic [nhpr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [nhpr_pkg::CsrDataWidth-1:0]   csr_wdata,
   // input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_req,
   input  logic [3:0]                          req_data_pins,
   input  logic                                req_tl_pin,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_th_level,
   output logic                                rsp_tr_level,
   output logic                                rsp_byte_valid,
   output logic [2:0]                          rsp_byte_index,
   output logic [7:0]                          rsp_byte_value,
   output logic                                rsp_timed_out,
   output logic                                rsp_done_res,
   output logic                                rsp_busy_res
);

`include "nibble_handshake_pad_reader_defines.svh"

   // byte counter must hold NUM_BYTES itself
   localparam int CW = $clog2(NUM_BYTES + 1);

   // csr registers
   logic [7:0] settle_ff, timeout_ff, end_ff;

   // sequencer state
   nhpr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          wc_ff, wc_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [3:0]          hi_ff, hi_in;
   logic                th_ff, th_in;
   logic                tr_ff, tr_in;
   logic                to_ff, to_in;

   // result buffer
   nhpr_pkg::rsp_type   out_ff, out_in, skid_ff, skid_in, res;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;

   logic                accept, out_take;
   logic [7:0]          wc_inc;
   logic                settle_hit, end_hit, tl_want, tl_fail;
   logic [CW-1:0]       cnt_inc;
   logic [CW+2:0]       cnt_ext;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff  <= nhpr_pkg::SettleReset;
         timeout_ff <= nhpr_pkg::TimeoutReset;
         end_ff     <= nhpr_pkg::EndReset;
      end else if (csr_we) begin
         unique case (csr_index)
            nhpr_pkg::CSR_SETTLE:  settle_ff  <= csr_wdata;
            nhpr_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            nhpr_pkg::CSR_END:     end_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // fixed waits act on the n-th tick in phase; a zero length acts as one
   assign wc_inc     = wc_ff + 8'd1;
   assign settle_hit = (wc_inc >= settle_ff);
   assign end_hit    = (wc_inc >= end_ff);
   // tl wait fails on the mismatch after timeout_ticks mismatches
   assign tl_want    = (phase_ff == nhpr_pkg::PH_WAIT_HI);
   assign tl_fail    = (wc_ff >= timeout_ff);
   assign cnt_inc    = cnt_ff + CW'(1);
   // byte index is the read position modulo eight
   assign cnt_ext    = {3'b000, cnt_ff};

   // sequencer step for one tick
   always_comb begin
      phase_in = phase_ff;
      wc_in    = wc_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      th_in    = th_ff;
      tr_in    = tr_ff;
      to_in    = to_ff;
      res      = '0;

      unique case (phase_ff) inside
         nhpr_pkg::PH_IDLE: begin
            if (req_start_req) begin
               th_in    = 1'b1;
               tr_in    = 1'b1;
               to_in    = 1'b0;
               cnt_in   = '0;
               wc_in    = '0;
               phase_in = nhpr_pkg::PH_SET_H0;
            end
         end
         nhpr_pkg::PH_SET_H0, nhpr_pkg::PH_SET_HN: begin
            if (settle_hit) begin
               wc_in = '0;
               hi_in = req_data_pins;
               if (phase_ff == nhpr_pkg::PH_SET_H0) begin
                  th_in    = 1'b0;
                  phase_in = nhpr_pkg::PH_SET_L0;
               end else begin
                  tr_in    = 1'b1;
                  phase_in = nhpr_pkg::PH_WAIT_HI;
               end
            end else begin
               wc_in = wc_inc;
            end
         end
         nhpr_pkg::PH_SET_L0, nhpr_pkg::PH_SET_LN: begin
            if (settle_hit) begin
               wc_in          = '0;
               res.byte_valid = 1'b1;
               res.byte_index = cnt_ext[2:0];
               res.byte_value = {hi_ff, req_data_pins};
               cnt_in         = cnt_inc;
               if (cnt_inc >= CW'(NUM_BYTES)) begin
                  phase_in = nhpr_pkg::PH_END1;
               end else begin
                  tr_in    = 1'b0;
                  phase_in = nhpr_pkg::PH_WAIT_LO;
               end
            end else begin
               wc_in = wc_inc;
            end
         end
         nhpr_pkg::PH_WAIT_LO, nhpr_pkg::PH_WAIT_HI: begin
            if (req_tl_pin == tl_want) begin
               wc_in    = '0;
               phase_in = tl_want ? nhpr_pkg::PH_SET_LN : nhpr_pkg::PH_SET_HN;
            end else if (tl_fail) begin
               // timed-out byte is presented as zero
               wc_in          = '0;
               res.byte_valid = 1'b1;
               res.byte_index = cnt_ext[2:0];
               to_in          = 1'b1;
               phase_in       = nhpr_pkg::PH_END1;
            end else begin
               wc_in = wc_inc;
            end
         end
         nhpr_pkg::PH_END1: begin
            if (end_hit) begin
               wc_in    = '0;
               th_in    = 1'b1;
               tr_in    = 1'b1;
               phase_in = nhpr_pkg::PH_END2;
            end else begin
               wc_in = wc_inc;
            end
         end
         nhpr_pkg::PH_END2: begin
            if (end_hit) begin
               wc_in        = '0;
               res.done_res = 1'b1;
               phase_in     = nhpr_pkg::PH_IDLE;
            end else begin
               wc_in = wc_inc;
            end
         end
         default: begin
            phase_in = nhpr_pkg::PH_IDLE;
            wc_in    = '0;
         end
      endcase

      // levels and status as they stand after the tick
      res.th_level  = th_in;
      res.tr_level  = tr_in;
      res.timed_out = to_in;
      res.busy_res  = (phase_in != nhpr_pkg::PH_IDLE);
   end

   // sequencer state advances only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= nhpr_pkg::PH_IDLE;
         wc_ff    <= '0;
         cnt_ff   <= '0;
         hi_ff    <= '0;
         th_ff    <= 1'b1;
         tr_ff    <= 1'b1;
         to_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         wc_ff    <= wc_in;
         cnt_ff   <= cnt_in;
         hi_ff    <= hi_in;
         th_ff    <= th_in;
         tr_ff    <= tr_in;
         to_ff    <= to_in;
      end
   end

   // output register plus skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // no intake; drain the skid entry once the output is taken
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && rsp_stall) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = res;
            out_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_th_level   = out_ff.th_level;
   assign rsp_tr_level   = out_ff.tr_level;
   assign rsp_byte_valid = out_ff.byte_valid;
   assign rsp_byte_index = out_ff.byte_index;
   assign rsp_byte_value = out_ff.byte_value;
   assign rsp_timed_out  = out_ff.timed_out;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_busy_res   = out_ff.busy_res;

   // skid entry only fills behind a held output
   `NHPR_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // every way into idle clears the wait counter
   `NHPR_ASSERT_IMPLIES(a_idle_wc_clear, clock, reset,
      phase_ff == nhpr_pkg::PH_IDLE, wc_ff == 8'd0)
   // a timeout always ends the read, never resumes a tl wait
   `NHPR_ASSERT_ALWAYS(a_timeout_ends, clock, reset,
      !(to_ff && (phase_ff == nhpr_pkg::PH_WAIT_LO || phase_ff == nhpr_pkg::PH_WAIT_HI)))
   // byte counter never passes the read length
   `NHPR_ASSERT_ALWAYS(a_count_bound, clock, reset, cnt_ff <= CW'(NUM_BYTES))

endmodule

[tb/sv/tb_nibble_handshake_pad_reader.sv]
// self-checking bench for the nibble handshake pad reader: tick stimulus with a pad
// that answers tr on tl, and a tracker that predicts every result item
// depends on nhpr_pkg and nibble_handshake_pad_reader
module tb_nibble_handshake_pad_reader;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ClockPeriod = 10;
   localparam int ReadBytes   = nhpr_pkg::NumBytesDefault;
   localparam int LimitNs     = 20_000_000;

   // tracks the sequencer tick by tick and holds the result items still owed
   class pad_sequence_tracker;
      nhpr_pkg::phase_type phase;
      logic [7:0]          settle, timeout, end_len;
      logic [7:0]          wait_count;
      int                  byte_count;
      logic [3:0]          upper_nib;
      logic                th_drive, tr_drive, timeout_seen;
      nhpr_pkg::rsp_type   expected_ticks[$];
      int                  errors;

      function new();
         settle       = nhpr_pkg::SettleReset;
         timeout      = nhpr_pkg::TimeoutReset;
         end_len      = nhpr_pkg::EndReset;
         phase        = nhpr_pkg::PH_IDLE;
         wait_count   = '0;
         byte_count   = 0;
         upper_nib    = '0;
         th_drive     = 1'b1;
         tr_drive     = 1'b1;
         timeout_seen = 1'b0;
         errors       = 0;
      endfunction

      function void write_reg(nhpr_pkg::csr_index_type idx, logic [7:0] value);
         case (idx)
            nhpr_pkg::CSR_SETTLE:  settle  = value;
            nhpr_pkg::CSR_TIMEOUT: timeout = value;
            nhpr_pkg::CSR_END:     end_len = value;
            default: ;
         endcase
      endfunction

      // fixed wait: true on the tick it runs out (zero length acts as one)
      function logic tick_wait(logic [7:0] len);
         wait_count = wait_count + 8'd1;
         if (wait_count >= len) begin
            wait_count = '0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_tick(logic start, logic [3:0] data, logic tl);
         nhpr_pkg::rsp_type want;
         logic              tl_ok;
         want = '0;
         case (phase)
            nhpr_pkg::PH_IDLE: begin
               if (start) begin
                  th_drive     = 1'b1;
                  tr_drive     = 1'b1;
                  timeout_seen = 1'b0;
                  byte_count   = 0;
                  wait_count   = '0;
                  phase        = nhpr_pkg::PH_SET_H0;
               end
            end
            nhpr_pkg::PH_SET_H0, nhpr_pkg::PH_SET_HN: begin
               if (tick_wait(settle)) begin
                  upper_nib = data;
                  if (phase == nhpr_pkg::PH_SET_H0) begin
                     th_drive = 1'b0;
                     phase    = nhpr_pkg::PH_SET_L0;
                  end else begin
                     tr_drive = 1'b1;
                     phase    = nhpr_pkg::PH_WAIT_HI;
                  end
               end
            end
            nhpr_pkg::PH_SET_L0, nhpr_pkg::PH_SET_LN: begin
               if (tick_wait(settle)) begin
                  want.byte_valid = 1'b1;
                  want.byte_index = byte_count[2:0];
                  want.byte_value = {upper_nib, data};
                  byte_count++;
                  if (byte_count >= ReadBytes) begin
                     phase = nhpr_pkg::PH_END1;
                  end else begin
                     tr_drive = 1'b0;
                     phase    = nhpr_pkg::PH_WAIT_LO;
                  end
               end
            end
            nhpr_pkg::PH_WAIT_LO, nhpr_pkg::PH_WAIT_HI: begin
               tl_ok = (tl == (phase == nhpr_pkg::PH_WAIT_HI));
               if (tl_ok) begin
                  wait_count = '0;
                  phase = (phase == nhpr_pkg::PH_WAIT_LO) ? nhpr_pkg::PH_SET_HN
                                                           : nhpr_pkg::PH_SET_LN;
               end else if (wait_count >= timeout) begin
                  wait_count      = '0;
                  want.byte_valid = 1'b1;
                  want.byte_index = byte_count[2:0];
                  want.byte_value = '0;
                  timeout_seen    = 1'b1;
                  phase           = nhpr_pkg::PH_END1;
               end else begin
                  wait_count = wait_count + 8'd1;
               end
            end
            nhpr_pkg::PH_END1: begin
               if (tick_wait(end_len)) begin
                  th_drive = 1'b1;
                  tr_drive = 1'b1;
                  phase    = nhpr_pkg::PH_END2;
               end
            end
            nhpr_pkg::PH_END2: begin
               if (tick_wait(end_len)) begin
                  want.done_res = 1'b1;
                  phase         = nhpr_pkg::PH_IDLE;
               end
            end
            default: begin
               phase      = nhpr_pkg::PH_IDLE;
               wait_count = '0;
            end
         endcase
         want.th_level  = th_drive;
         want.tr_level  = tr_drive;
         want.timed_out = timeout_seen;
         want.busy_res  = (phase != nhpr_pkg::PH_IDLE);
         expected_ticks.push_back(want);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s expected %0h got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_tick(nhpr_pkg::rsp_type got);
         nhpr_pkg::rsp_type want;
         if (expected_ticks.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
            return;
         end
         want = expected_ticks.pop_front();
         check_field("th_level", want.th_level, got.th_level);
         check_field("tr_level", want.tr_level, got.tr_level);
         check_field("byte_valid", want.byte_valid, got.byte_valid);
         check_field("byte_index", want.byte_index, got.byte_index);
         check_field("byte_value", want.byte_value, got.byte_value);
         check_field("timed_out", want.timed_out, got.timed_out);
         check_field("done_res", want.done_res, got.done_res);
         check_field("busy_res", want.busy_res, got.busy_res);
      endfunction
   endclass

   // how the simulated pad answers tr on its tl line
   typedef enum logic [1:0] {
      PAD_PROMPT,   // follows tr after a few ticks
      PAD_SLOW,     // follows tr after up to the timeout and a bit more
      PAD_NOISY,    // tl random every tick
      PAD_DEAD      // tl never moves
   } pad_mode_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_we = 1'b0;
   logic [nhpr_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [nhpr_pkg::CsrDataWidth-1:0]  csr_wdata = '0;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_start_req = 1'b0;
   logic [3:0]                         req_data_pins = '0;
   logic                               req_tl_pin = 1'b1;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_th_level;
   logic                               rsp_tr_level;
   logic                               rsp_byte_valid;
   logic [2:0]                         rsp_byte_index;
   logic [7:0]                         rsp_byte_value;
   logic                               rsp_timed_out;
   logic                               rsp_done_res;
   logic                               rsp_busy_res;

   pad_sequence_tracker tracker;

   // both sides stop idling while this is set
   logic         calm = 1'b0;

   // pad state: current tl level, the tr level it is chasing, ticks left
   pad_mode_type pad_mode = PAD_PROMPT;
   logic         pad_tl = 1'b1;
   logic         pad_target = 1'b1;
   int           pad_delay = 0;

   nibble_handshake_pad_reader #(
      .NUM_BYTES(ReadBytes)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .req_data_pins (req_data_pins),
      .req_tl_pin    (req_tl_pin),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_th_level  (rsp_th_level),
      .rsp_tr_level  (rsp_tr_level),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_byte_index(rsp_byte_index),
      .rsp_byte_value(rsp_byte_value),
      .rsp_timed_out (rsp_timed_out),
      .rsp_done_res  (rsp_done_res),
      .rsp_busy_res  (rsp_busy_res)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // result side: check what is taken at this edge, then pick the next stall
   always @(posedge clock) begin : rsp_side
      nhpr_pkg::rsp_type seen;
      seen.th_level   = rsp_th_level;
      seen.tr_level   = rsp_tr_level;
      seen.byte_valid = rsp_byte_valid;
      seen.byte_index = rsp_byte_index;
      seen.byte_value = rsp_byte_value;
      seen.timed_out  = rsp_timed_out;
      seen.done_res   = rsp_done_res;
      seen.busy_res   = rsp_busy_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_tick(seen);
      end
      rsp_stall <= !calm && ($urandom_range(99) < 36);
   end

   // tl level the pad shows on the next tick, given the tr level now driven
   function logic pad_level();
      if (tracker.tr_drive != pad_target) begin
         pad_target = tracker.tr_drive;
         pad_delay  = (pad_mode == PAD_SLOW) ? $urandom_range(int'(tracker.timeout) + 3)
                                             : $urandom_range(3);
      end
      case (pad_mode)
         PAD_NOISY: pad_tl = 1'($urandom_range(1));
         PAD_DEAD:  ;
         default: begin
            if (pad_tl != pad_target) begin
               if (pad_delay == 0) begin
                  pad_tl = pad_target;
               end else begin
                  pad_delay--;
               end
            end
         end
      endcase
      return pad_tl;
   endfunction

   // one tick item: optional idle gap, then hold it until taken
   task automatic send_tick(input logic start, input logic [3:0] data, input logic tl);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      req_data_pins <= data;
      req_tl_pin    <= tl;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      tracker.note_tick(start, data, tl);
   endtask

   task automatic write_csr(input nhpr_pkg::csr_index_type idx, input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_reg(idx, value);
   endtask

   task automatic set_timing(input logic [7:0] settle, input logic [7:0] timeout,
                             input logic [7:0] end_len);
      write_csr(nhpr_pkg::CSR_SETTLE, settle);
      write_csr(nhpr_pkg::CSR_TIMEOUT, timeout);
      write_csr(nhpr_pkg::CSR_END, end_len);
   endtask

   // run the open read out, then let every owed result drain
   task automatic finish_read();
      while (tracker.phase != nhpr_pkg::PH_IDLE) begin
         send_tick(1'b0, 4'($urandom_range(15)), pad_level());
      end
      req_valid <= 1'b0;
      while (tracker.expected_ticks.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // reads with random pad data and pad behavior; budget counts only
   // items that start or step a read
   task automatic run_reads(input logic [7:0] settle, input logic [7:0] timeout,
                            input logic [7:0] end_len, input int budget);
      int   spent;
      logic start;
      logic idle;
      spent = 0;
      set_timing(settle, timeout, end_len);
      while (spent < budget) begin
         idle = (tracker.phase == nhpr_pkg::PH_IDLE);
         if (idle) begin
            case ($urandom_range(19))
               0, 1, 2:  pad_mode = PAD_SLOW;
               3, 4, 5:  pad_mode = PAD_NOISY;
               6, 7, 8:  pad_mode = PAD_DEAD;
               default:  pad_mode = PAD_PROMPT;
            endcase
            start = ($urandom_range(3) != 0);
         end else begin
            // a start while busy must be ignored
            start = ($urandom_range(3) == 0);
         end
         if (!idle || start) begin
            spent++;
         end
         send_tick(start, 4'($urandom_range(15)), pad_level());
      end
      finish_read();
   endtask

   // short hand-made reads: data extremes, start while busy, zero settle,
   // a timeout waiting for tl low and one waiting for tl high
   task automatic run_directed();
      logic [5:0] ticks[$];
      // each entry is {start, data, tl}
      ticks = '{
         {1'b1, 4'h0, 1'b1}, {1'b1, 4'hF, 1'b0}, {1'b0, 4'hF, 1'b1},
         {1'b0, 4'h0, 1'b1}, {1'b0, 4'h0, 1'b1}, {1'b0, 4'h0, 1'b1},
         {1'b0, 4'h0, 1'b1}, {1'b0, 4'h0, 1'b1},
         {1'b1, 4'h5, 1'b1}, {1'b0, 4'h0, 1'b1}, {1'b0, 4'h0, 1'b0},
         {1'b1, 4'hA, 1'b0}, {1'b0, 4'hA, 1'b0}, {1'b0, 4'h5, 1'b1},
         {1'b0, 4'h5, 1'b1}, {1'b0, 4'h0, 1'b0}, {1'b0, 4'h0, 1'b0},
         {1'b0, 4'h0, 1'b0}, {1'b0, 4'h0, 1'b0}, {1'b0, 4'h0, 1'b0},
         {1'b0, 4'h0, 1'b1}, {1'b0, 4'h0, 1'b1}, {1'b0, 4'h0, 1'b1}
      };
      set_timing(8'd0, 8'd2, 8'd1);
      foreach (ticks[i]) begin
         send_tick(ticks[i][5], ticks[i][4:1], ticks[i][0]);
      end
      finish_read();
   endtask

   initial begin
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // back to the reset timing, then small, zero and mixed settings
      run_reads(nhpr_pkg::SettleReset, nhpr_pkg::TimeoutReset, nhpr_pkg::EndReset, 150);
      run_reads(8'd1, 8'd1, 8'd1, 150);
      run_reads(8'd0, 8'd0, 8'd0, 120);

      // no idling on either side for this whole stretch
      calm = 1'b1;
      run_reads(8'd3, 8'd5, 8'd2, 150);
      calm = 1'b0;

      run_reads(8'd1, 8'd255, 8'd1, 100);
      run_reads(8'd4, 8'd20, 8'd7, 80);

      // let anything stray come out before the verdict
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_ticks.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #(LimitNs);
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/nhpr_pkg.sv
sv/nibble_handshake_pad_reader.sv
tb/sv/tb_nibble_handshake_pad_reader.sv
